/* rtl/core/assert_macros.svh */
// Assertion helpers used by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge once reset has been released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/bfpag_pkg.sv */
package bfpag_pkg;

    localparam int unsigned BANDS  = 4;
    localparam int unsigned BAND_W = 2;
    localparam int unsigned LVL_W  = 16;
    localparam int unsigned ST_W   = 24;
    localparam int unsigned ACC_W  = 41;
    localparam int unsigned MPL_W  = 17;
    localparam int unsigned CNT_W  = 5;

    localparam logic [ST_W-1:0]  FULL24     = 24'hFFFFFF;
    localparam logic [LVL_W-1:0] W_OLD      = 16'd45875;
    localparam logic [LVL_W-1:0] W_NEW      = 16'd19661;
    localparam logic [ACC_W-1:0] ROUND_HALF = 41'd32768;

    // step counts minus one for the serial units
    localparam logic [CNT_W-1:0] LAST_16 = 5'd15;
    localparam logic [CNT_W-1:0] LAST_17 = 5'd16;

    localparam logic [15:0] RST_PEAK_DECAY = 16'd65208;
    localparam logic [16:0] RST_FLOOR_RISE = 17'd65667;
    localparam logic [15:0] RST_MIN_RATIO  = 16'd768;

    localparam logic [1:0] CFG_PEAK_DECAY = 2'd0;
    localparam logic [1:0] CFG_FLOOR_RISE = 2'd1;
    localparam logic [1:0] CFG_MIN_RATIO  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MUL_S,
        S_MUL_X,
        S_MUL_P,
        S_MUL_F,
        S_MUL_R,
        S_DIV,
        S_NEXT,
        S_DONE
    } t_state;

endpackage

/* rtl/core/band_floor_peak_auto_gain_core.sv */
// Four-band auto-gain normalizer with peak and floor tracking.
// Input stream (i_s_*): one word per frame, four unsigned Q0.16 band levels.
// Output stream (o_m_*): one word per frame, four Q0.16 normalized levels,
//   65535 meaning one. Per band the block smooths the level, lets the peak
//   decay and the floor rise, and outputs (level-floor)/(peak-floor), or zero
//   when the peak stays below floor times min ratio, or level <= floor.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 peak decay, 1 floor rise, 2 min ratio); other indexes are ignored.
//   Write only while no frame is in flight.
// Timing: the bands go one after another through one bit-serial shift-add
//   multiplier (five products of 16 or 17 steps) and one restoring divider
//   (16 steps, skipped when the result is zero or full scale). A new frame
//   is accepted only once the previous result is in the output register.
// Reset: the config registers return to their defaults, smoothed levels and
//   peaks clear to zero, floors go to full scale, both streams go idle.
// Stall: a finished result waits in the output register; the next frame is
//   accepted and worked on meanwhile, and only the hand-off of its own result
//   waits until the output register is free.
`include "assert_macros.svh"

module band_floor_peak_auto_gain_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [15:0] bass_level, [31:16] low_mid_level, [47:32] mid_level, [63:48] high_level
    input  logic [63:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] bass_norm, [31:16] low_mid_norm, [47:32] mid_norm, [63:48] high_norm
    output logic [63:0] o_m_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data
);

    bfpag_pkg::t_state r_state;
    bfpag_pkg::t_state n_state;

    // configuration
    logic [15:0] r_decay;
    logic [16:0] r_rise;
    logic [15:0] r_ratio;

    // per-band tracking state
    logic [bfpag_pkg::ST_W-1:0] r_smooth [bfpag_pkg::BANDS];
    logic [bfpag_pkg::ST_W-1:0] r_peak   [bfpag_pkg::BANDS];
    logic [bfpag_pkg::ST_W-1:0] r_floor  [bfpag_pkg::BANDS];

    logic [bfpag_pkg::BAND_W-1:0] r_band;
    logic [bfpag_pkg::CNT_W-1:0]  r_cnt;
    logic                         r_ovalid;
    logic [63:0]                  r_odata;

    // frame and result shift lines, one band per shift
    logic [63:0] r_in;
    logic [63:0] r_res;

    // serial multiplier
    logic [bfpag_pkg::ACC_W-1:0] r_acc;
    logic [bfpag_pkg::ACC_W-1:0] r_mcand;
    logic [bfpag_pkg::MPL_W-1:0] r_mplier;

    // band working values and divider
    logic [bfpag_pkg::ST_W-1:0] r_lvl;
    logic [bfpag_pkg::ST_W-1:0] r_pk;
    logic [bfpag_pkg::ST_W-1:0] r_fl;
    logic [bfpag_pkg::ST_W-1:0] r_rem;
    logic [bfpag_pkg::ST_W-1:0] r_den;
    logic [15:0]                r_q;

    // control decode
    logic c_s_ready;
    logic c_last;
    logic c_out_free;

    // datapath helpers
    logic [bfpag_pkg::ACC_W-1:0] c_acc_nx;
    logic [bfpag_pkg::ST_W:0]    c_lvl_raw;
    logic [bfpag_pkg::ST_W-1:0]  c_lvl;
    logic [bfpag_pkg::ST_W-1:0]  c_pkd;
    logic [bfpag_pkg::ST_W-1:0]  c_pk_max;
    logic [bfpag_pkg::ST_W-1:0]  c_pk_new;
    logic [bfpag_pkg::ST_W+1:0]  c_risen_raw;
    logic [bfpag_pkg::ST_W-1:0]  c_risen;
    logic [bfpag_pkg::ST_W-1:0]  c_fl_min;
    logic [bfpag_pkg::ST_W-1:0]  c_fl_new;
    logic                        c_zero;
    logic                        c_sat;
    logic [bfpag_pkg::ST_W:0]    c_rem2;
    logic                        c_ge;
    logic [bfpag_pkg::ST_W:0]    c_rem_sub;

    assign c_acc_nx    = r_acc + (r_mplier[0] ? r_mcand : '0);
    assign c_lvl_raw   = c_acc_nx[40:16];
    assign c_lvl       = (c_lvl_raw > {1'b0, bfpag_pkg::FULL24}) ? bfpag_pkg::FULL24
                                                                 : c_lvl_raw[23:0];
    assign c_pkd       = c_acc_nx[39:16];
    assign c_pk_max    = (r_lvl > c_pkd) ? r_lvl : c_pkd;
    assign c_pk_new    = (c_pk_max == '0) ? 24'd1 : c_pk_max;
    assign c_risen_raw = {1'b0, c_acc_nx[40:16]} + 26'd1;
    assign c_risen     = (c_risen_raw > {2'b00, bfpag_pkg::FULL24}) ? bfpag_pkg::FULL24
                                                                    : c_risen_raw[23:0];
    assign c_fl_min    = (r_lvl < c_risen) ? r_lvl : c_risen;
    assign c_fl_new    = (c_fl_min == '0) ? 24'd1 : c_fl_min;
    // too little range, or level at or under the floor: output zero
    assign c_zero      = ({9'd0, r_pk, 8'd0} < c_acc_nx) || (r_lvl <= r_fl);
    // level is never above peak, so level equal to peak means a quotient of one
    assign c_sat       = (r_lvl == r_pk);
    assign c_rem2      = {r_rem, 1'b0};
    assign c_ge        = (c_rem2 >= {1'b0, r_den});
    assign c_rem_sub   = c_rem2 - {1'b0, r_den};

    // output decode
    always_comb begin
        c_s_ready  = (r_state == bfpag_pkg::S_IDLE);
        c_last     = (r_cnt == '0);
        c_out_free = !r_ovalid || i_m_tready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfpag_pkg::S_IDLE:  if (i_s_tvalid) n_state = bfpag_pkg::S_LOAD;
            bfpag_pkg::S_LOAD:  n_state = bfpag_pkg::S_MUL_S;
            bfpag_pkg::S_MUL_S: if (c_last) n_state = bfpag_pkg::S_MUL_X;
            bfpag_pkg::S_MUL_X: if (c_last) n_state = bfpag_pkg::S_MUL_P;
            bfpag_pkg::S_MUL_P: if (c_last) n_state = bfpag_pkg::S_MUL_F;
            bfpag_pkg::S_MUL_F: if (c_last) n_state = bfpag_pkg::S_MUL_R;
            bfpag_pkg::S_MUL_R: begin
                if (c_last) n_state = (c_zero || c_sat) ? bfpag_pkg::S_NEXT
                                                        : bfpag_pkg::S_DIV;
            end
            bfpag_pkg::S_DIV:   if (c_last) n_state = bfpag_pkg::S_NEXT;
            bfpag_pkg::S_NEXT: begin
                n_state = (r_band == 2'd3) ? bfpag_pkg::S_DONE : bfpag_pkg::S_LOAD;
            end
            bfpag_pkg::S_DONE:  if (c_out_free) n_state = bfpag_pkg::S_IDLE;
            default:            n_state = bfpag_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bfpag_pkg::S_IDLE;
            r_band   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_decay  <= bfpag_pkg::RST_PEAK_DECAY;
            r_rise   <= bfpag_pkg::RST_FLOOR_RISE;
            r_ratio  <= bfpag_pkg::RST_MIN_RATIO;
            for (int b = 0; b < bfpag_pkg::BANDS; b++) begin
                r_smooth[b] <= '0;
                r_peak[b]   <= '0;
                r_floor[b]  <= bfpag_pkg::FULL24;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bfpag_pkg::CFG_PEAK_DECAY: r_decay <= i_cfg_data[15:0];
                    bfpag_pkg::CFG_FLOOR_RISE: r_rise  <= i_cfg_data;
                    bfpag_pkg::CFG_MIN_RATIO:  r_ratio <= i_cfg_data[15:0];
                    default:                   ;
                endcase
            end

            // load a finished frame into the output register, drop it once taken
            if (r_state == bfpag_pkg::S_DONE && c_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                bfpag_pkg::S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_in   <= i_s_tdata;
                        r_band <= '0;
                    end
                end
                bfpag_pkg::S_LOAD: begin
                    r_acc    <= bfpag_pkg::ROUND_HALF;
                    r_mcand  <= {17'd0, r_smooth[r_band]};
                    r_mplier <= {1'b0, bfpag_pkg::W_OLD};
                    r_cnt    <= bfpag_pkg::LAST_16;
                end
                bfpag_pkg::S_MUL_S, bfpag_pkg::S_MUL_X, bfpag_pkg::S_MUL_P,
                bfpag_pkg::S_MUL_F, bfpag_pkg::S_MUL_R: begin
                    // one multiplier bit per cycle
                    r_acc    <= c_acc_nx;
                    r_mcand  <= {r_mcand[39:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[16:1]};
                    r_cnt    <= r_cnt - 5'd1;
                    if (c_last) begin
                        case (r_state)
                            bfpag_pkg::S_MUL_S: begin
                                // keep the sum, add the new sample term
                                r_mcand  <= {17'd0, r_in[15:0], 8'd0};
                                r_mplier <= {1'b0, bfpag_pkg::W_NEW};
                                r_cnt    <= bfpag_pkg::LAST_16;
                            end
                            bfpag_pkg::S_MUL_X: begin
                                r_lvl    <= c_lvl;
                                r_acc    <= '0;
                                r_mcand  <= {17'd0, r_peak[r_band]};
                                r_mplier <= {1'b0, r_decay};
                                r_cnt    <= bfpag_pkg::LAST_16;
                            end
                            bfpag_pkg::S_MUL_P: begin
                                r_pk     <= c_pk_new;
                                r_acc    <= '0;
                                r_mcand  <= {17'd0, r_floor[r_band]};
                                r_mplier <= r_rise;
                                r_cnt    <= bfpag_pkg::LAST_17;
                            end
                            bfpag_pkg::S_MUL_F: begin
                                r_fl             <= c_fl_new;
                                r_smooth[r_band] <= r_lvl;
                                r_peak[r_band]   <= r_pk;
                                r_floor[r_band]  <= c_fl_new;
                                r_acc            <= '0;
                                r_mcand          <= {17'd0, c_fl_new};
                                r_mplier         <= {1'b0, r_ratio};
                                r_cnt            <= bfpag_pkg::LAST_16;
                            end
                            default: begin
                                // ratio check done: seed the divider
                                r_q   <= c_zero ? 16'd0 : 16'hFFFF;
                                r_rem <= r_lvl - r_fl;
                                r_den <= r_pk - r_fl;
                                r_cnt <= bfpag_pkg::LAST_16;
                            end
                        endcase
                    end
                end
                bfpag_pkg::S_DIV: begin
                    // one quotient bit per cycle
                    r_rem <= c_ge ? c_rem_sub[23:0] : c_rem2[23:0];
                    r_q   <= {r_q[14:0], c_ge};
                    r_cnt <= r_cnt - 5'd1;
                end
                bfpag_pkg::S_NEXT: begin
                    r_res  <= {r_q, r_res[63:16]};
                    r_in   <= {16'd0, r_in[63:16]};
                    r_band <= r_band + 2'd1;
                end
                bfpag_pkg::S_DONE: begin
                    if (c_out_free) r_odata <= r_res;
                end
                default: ;
            endcase
        end
    end

    assign o_s_tready = c_s_ready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    `ASSERT_CLK(a_accept_starts_band0, i_clk, i_rst_n,
        (i_s_tvalid && o_s_tready) |=> (r_state == bfpag_pkg::S_LOAD && r_band == '0),
        "frame accept did not start at the first band")
    `ASSERT_CLK(a_div_rem_below_den, i_clk, i_rst_n,
        (r_state == bfpag_pkg::S_DIV) |-> (r_rem < r_den),
        "divider remainder not below divisor")
    `ASSERT_CLK(a_done_hands_off, i_clk, i_rst_n,
        (r_state == bfpag_pkg::S_DONE && c_out_free) |=> (o_m_tvalid && o_s_tready),
        "finished frame not handed to the output register")
    `ASSERT_CLK(a_peak_over_level, i_clk, i_rst_n,
        (r_peak[0] >= r_smooth[0]) && (r_peak[1] >= r_smooth[1]) &&
        (r_peak[2] >= r_smooth[2]) && (r_peak[3] >= r_smooth[3]),
        "stored peak below smoothed level")
    `ASSERT_ALWAYS(a_reset_idles, i_clk,
        !i_rst_n |=> (!o_m_tvalid && r_state == bfpag_pkg::S_IDLE),
        "reset did not idle the block")

endmodule
